// File: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Field widths of the request, response and register ports
   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ADDR_W     = 11;
   localparam int ROWCNT_W   = 8;
   localparam int TAB_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int CELL_W     = CHAR_W + ATTR_W;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUT        = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_CURSOR = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_COLOR = 2'd1;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // Register defaults and limits
   localparam logic [TAB_W-1:0]      TAB_DEFAULT   = 4'd5;
   localparam logic [CSR_DATA_W-1:0] TAB_MIN       = 8'd1;
   localparam logic [CSR_DATA_W-1:0] TAB_MAX       = 8'd8;
   localparam logic [ATTR_W-1:0]     BLANK_DEFAULT = 8'h07;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_TAB_MOD,
      ST_PUT,
      ST_FILL,
      ST_SET_MOD,
      ST_RD_WAIT,
      ST_RESPOND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture the request beat
      logic char_init;   // one character to write
      logic rem_tab;     // start column mod tab width
      logic rem_set;     // start address mod columns
      logic tab_load;    // space count from the remainder
      logic put_step;    // write one character at the cursor
      logic cur_load;    // cursor from address and remainder
      logic mem_rd;      // read the addressed cell
      logic fill_start;  // set up a row fill
      logic fill_many;   // fill the requested rows, else one row
      logic fill_step;   // write one blank cell
      logic respond;     // load the response registers
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              is_tab;
      logic              addr_ok;
      logic              rows_zero;
      logic              put_wrap;
      logic              cnt_last;
      logic              cnt_zero;
      logic              fill_last;
      logic              rem_done;
   } status_type;

endpackage

// File: hw/rtl/tcw_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module tcw_rem
   import tcw_pkg::*;
#(
   parameter int DVD_W = 11,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] shift_ff, shift_in;
   logic [DVS_W-1:0] part_ff, part_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial    = {part_ff, shift_ff[DVD_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      part_in  = part_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = CNT_W'(DVD_W);
         shift_in = dividend;
         part_in  = '0;
         dvs_in   = divisor;
      end else if (run_ff) begin
         shift_in = {shift_ff[DVD_W-2:0], 1'b0};
         part_in  = (trial >= {1'b0, dvs_ff}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      part_ff  <= part_in;
      dvs_ff   <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = part_ff;

endmodule

// File: hw/rtl/tcw_dp.sv
// Datapath: cell store, cursor, row offset, fill walker and response registers.
`timescale 1ns / 1ps

module tcw_dp
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [ATTR_W-1:0]     req_attr,
   input  logic [ADDR_W-1:0]     req_cell_addr,
   input  logic [ROWCNT_W-1:0]   req_row_count,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_cursor_pos,
   output logic [CHAR_W-1:0]     rsp_read_char,
   output logic [ATTR_W-1:0]     rsp_read_attr,
   output logic                  rsp_did_scroll
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CUR_W = $clog2(CELLS);
   localparam int SUM_W = CUR_W + 1;
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS + 1);
   localparam int DIV_W = $clog2(COLUMNS + 1);
   localparam int AX_W  = (ADDR_W > CUR_W) ? ADDR_W : CUR_W;

   // Row of an address by reciprocal multiplication
   localparam int QSH     = CUR_W + COL_W;
   localparam int RECIP_W = CUR_W + 1;
   localparam int PROD_W  = CUR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << QSH) + COLUMNS - 1) / COLUMNS);

   // Request beat
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ROWCNT_W-1:0] rows_ff, rows_in;

   // Screen state
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CUR_W-1:0] off_ff, off_in;
   logic [TAB_W-1:0] cnt_ff, cnt_in;
   logic             scrolled_ff, scrolled_in;

   // Cursor set: row of the address, then its column
   logic [ROW_W-1:0] set_row_ff, set_row_in;
   logic             set_done_ff, set_done_in;

   // Fill walker
   logic [CUR_W-1:0]  fill_ptr_ff, fill_ptr_in;
   logic [COL_W-1:0]  fill_col_ff, fill_col_in;
   logic [ROW_W-1:0]  fill_row_ff, fill_row_in;
   logic [ROW_W-1:0]  fill_rows_ff, fill_rows_in;
   logic [CELL_W-1:0] fill_word_ff, fill_word_in;

   // Registers
   logic [TAB_W-1:0]  tab_w_ff, tab_w_in;
   logic [ATTR_W-1:0] blank_ff, blank_in;

   // Response
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic              rsp_scroll_ff, rsp_scroll_in;

   // Cell store
   logic [CELL_W-1:0] cell_mem [CELLS];
   logic [CELL_W-1:0] rd_q_ff;

   logic              addr_ok;
   logic              is_tab;
   logic              is_nl;
   logic [CHAR_W-1:0] put_char;
   logic [CUR_W-1:0]  log_addr;
   logic [SUM_W-1:0]  phys_sum;
   logic [SUM_W-1:0]  phys_diff;
   logic [CUR_W-1:0]  phys;
   logic              col_last;
   logic [SUM_W-1:0]  step_pos;
   logic [SUM_W-1:0]  step_back;
   logic              put_wrap;
   logic [CUR_W-1:0]  put_cursor;
   logic [COL_W-1:0]  put_col;
   logic [CUR_W-1:0]  fill_ptr_inc;
   logic              fill_col_last;
   logic              fill_last;
   logic [ROW_W-1:0]  rows_cap;
   logic [PROD_W-1:0] set_prod;
   logic [CUR_W-1:0]  set_base;
   logic [CUR_W-1:0]  set_col;
   logic              mem_we;
   logic [CUR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              rem_start;
   logic [CUR_W-1:0]  rem_dividend;
   logic [DIV_W-1:0]  rem_divisor;
   logic              rem_done;
   logic [DIV_W-1:0]  rem_value;

   // Request decode
   assign addr_ok  = AX_W'(addr_ff) < AX_W'(CELLS);
   assign is_tab   = (char_ff == CH_TAB);
   assign is_nl    = (char_ff == CH_NL);
   assign put_char = is_tab ? CH_SPACE : char_ff;
   assign rows_cap = (rows_ff > ROWCNT_W'(ROWS)) ? ROW_W'(ROWS) : ROW_W'(rows_ff);

   // Logical cell to store address: rows rotate by the offset
   assign log_addr  = (func_ff == FUNC_READ) ? CUR_W'(addr_ff) : cursor_ff;
   assign phys_sum  = {1'b0, log_addr} + {1'b0, off_ff};
   assign phys_diff = phys_sum - SUM_W'(CELLS);
   assign phys      = (phys_sum >= SUM_W'(CELLS)) ? phys_diff[CUR_W-1:0] : phys_sum[CUR_W-1:0];

   // Cursor advance for one character or newline
   assign col_last   = (col_ff == COL_W'(COLUMNS - 1));
   assign step_pos   = is_nl ? ({1'b0, cursor_ff} + SUM_W'(COLUMNS) - SUM_W'(col_ff))
                             : ({1'b0, cursor_ff} + SUM_W'(1));
   assign step_back  = step_pos - SUM_W'(COLUMNS);
   assign put_wrap   = (step_pos >= SUM_W'(CELLS));
   assign put_cursor = put_wrap ? step_back[CUR_W-1:0] : step_pos[CUR_W-1:0];
   assign put_col    = (is_nl || col_last) ? '0 : col_ff + 1'b1;

   // Fill walker stepping
   assign fill_ptr_inc  = (fill_ptr_ff == CUR_W'(CELLS - 1)) ? '0 : fill_ptr_ff + 1'b1;
   assign fill_col_last = (fill_col_ff == COL_W'(COLUMNS - 1));
   assign fill_last     = fill_col_last && (fill_row_ff == fill_rows_ff - 1'b1);

   // Cursor set: row in the first cycle, column from the registered row in the next
   assign set_prod = PROD_W'(CUR_W'(addr_ff)) * PROD_W'(RECIP);
   assign set_base = CUR_W'(set_row_ff) * CUR_W'(COLUMNS);
   assign set_col  = CUR_W'(addr_ff) - set_base;

   // Remainder unit: column mod tab width
   assign rem_start    = cmd.rem_tab;
   assign rem_dividend = CUR_W'(col_ff);
   assign rem_divisor  = DIV_W'(tab_w_ff);

   tcw_rem #(
      .DVD_W(CUR_W),
      .DVS_W(DIV_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .done     (rem_done),
      .remainder(rem_value)
   );

   // Next state of all registers
   always_comb begin
      func_in       = func_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      addr_in       = addr_ff;
      rows_in       = rows_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      off_in        = off_ff;
      cnt_in        = cnt_ff;
      scrolled_in   = scrolled_ff;
      set_row_in    = set_row_ff;
      set_done_in   = cmd.rem_set;
      fill_ptr_in   = fill_ptr_ff;
      fill_col_in   = fill_col_ff;
      fill_row_in   = fill_row_ff;
      fill_rows_in  = fill_rows_ff;
      fill_word_in  = fill_word_ff;
      tab_w_in      = tab_w_ff;
      blank_in      = blank_ff;
      rsp_valid_in  = cmd.respond;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_scroll_in = rsp_scroll_ff;

      if (cmd.load) begin
         func_in     = req_func;
         char_in     = req_char_code;
         attr_in     = req_attr;
         addr_in     = req_cell_addr;
         rows_in     = req_row_count;
         cnt_in      = '0;
         scrolled_in = 1'b0;
      end
      if (cmd.char_init) begin
         cnt_in = TAB_W'(1);
      end
      if (cmd.tab_load) begin
         cnt_in = tab_w_ff - rem_value[TAB_W-1:0];
      end
      if (cmd.rem_set) begin
         set_row_in = ROW_W'(set_prod >> QSH);
      end
      if (cmd.put_step) begin
         cursor_in = put_cursor;
         col_in    = put_col;
         cnt_in    = cnt_ff - 1'b1;
         if (put_wrap) begin
            scrolled_in = 1'b1;
         end
      end
      if (cmd.cur_load) begin
         cursor_in = CUR_W'(addr_ff);
         col_in    = set_col[COL_W-1:0];
      end
      if (cmd.fill_start) begin
         fill_ptr_in  = off_ff;
         fill_col_in  = '0;
         fill_row_in  = '0;
         fill_rows_in = cmd.fill_many ? rows_cap : ROW_W'(1);
         fill_word_in = {blank_ff, CH_SPACE};
         if (cmd.fill_many) begin
            scrolled_in = 1'b1;
         end
      end
      // Old top rows become the new bottom rows once blanked
      if (cmd.fill_step) begin
         fill_ptr_in = fill_ptr_inc;
         fill_col_in = fill_col_last ? '0 : fill_col_ff + 1'b1;
         fill_row_in = fill_col_last ? fill_row_ff + 1'b1 : fill_row_ff;
         if (fill_last) begin
            off_in = fill_ptr_inc;
         end
      end

      // Register writes
      if (csr_write_enable) begin
         if (csr_index == CSR_TAB_WIDTH) begin
            if (csr_write_data >= TAB_MIN && csr_write_data <= TAB_MAX) begin
               tab_w_in = TAB_W'(csr_write_data);
            end
         end else if (csr_index == CSR_BLANK_COLOR) begin
            blank_in = csr_write_data;
         end
      end

      // Response beat
      if (cmd.respond) begin
         rsp_cursor_in = ADDR_W'(cursor_ff);
         rsp_scroll_in = scrolled_ff;
         if (func_ff == FUNC_READ && addr_ok) begin
            rsp_char_in = rd_q_ff[CHAR_W-1:0];
            rsp_attr_in = rd_q_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_in = '0;
            rsp_attr_in = '0;
         end
      end
   end

   // Control registers; the fill walker starts out clearing the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         scrolled_ff  <= 1'b0;
         set_done_ff  <= 1'b0;
         fill_ptr_ff  <= '0;
         fill_col_ff  <= '0;
         fill_row_ff  <= '0;
         fill_rows_ff <= ROW_W'(ROWS);
         fill_word_ff <= '0;
         tab_w_ff     <= TAB_DEFAULT;
         blank_ff     <= BLANK_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         scrolled_ff  <= scrolled_in;
         set_done_ff  <= set_done_in;
         fill_ptr_ff  <= fill_ptr_in;
         fill_col_ff  <= fill_col_in;
         fill_row_ff  <= fill_row_in;
         fill_rows_ff <= fill_rows_in;
         fill_word_ff <= fill_word_in;
         tab_w_ff     <= tab_w_in;
         blank_ff     <= blank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      char_ff       <= char_in;
      attr_ff       <= attr_in;
      addr_ff       <= addr_in;
      rows_ff       <= rows_in;
      set_row_ff    <= set_row_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   // Cell store write port: put or fill
   assign mem_we    = (cmd.put_step && !is_nl) || cmd.fill_step;
   assign mem_waddr = cmd.fill_step ? fill_ptr_ff : phys;
   assign mem_wdata = cmd.fill_step ? fill_word_ff : {attr_ff, put_char};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Cell store read port
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_q_ff <= cell_mem[phys];
      end
   end

   // Status back to the controller
   always_comb begin
      status.func      = func_ff;
      status.is_tab    = is_tab;
      status.addr_ok   = addr_ok;
      status.rows_zero = (rows_ff == '0);
      status.put_wrap  = put_wrap;
      status.cnt_last  = (cnt_ff == TAB_W'(1));
      status.cnt_zero  = (cnt_ff == '0);
      status.fill_last = fill_last;
      status.rem_done  = rem_done || set_done_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_attr  = rsp_attr_ff;
   assign rsp_did_scroll = rsp_scroll_ff;

endmodule

// File: hw/rtl/tcw_ctrl.sv
// Controller: sequences each operation over the datapath.
`timescale 1ns / 1ps

module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register; reset begins with the store clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_PUT: begin
                  if (status.is_tab) begin
                     cmd.rem_tab = 1'b1;
                     state_in    = ST_TAB_MOD;
                  end else begin
                     cmd.char_init = 1'b1;
                     state_in      = ST_PUT;
                  end
               end
               FUNC_READ: begin
                  if (status.addr_ok) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = ST_RD_WAIT;
                  end else begin
                     state_in = ST_RESPOND;
                  end
               end
               FUNC_SET_CURSOR: begin
                  if (status.addr_ok) begin
                     cmd.rem_set = 1'b1;
                     state_in    = ST_SET_MOD;
                  end else begin
                     state_in = ST_RESPOND;
                  end
               end
               FUNC_SCROLL: begin
                  if (!status.rows_zero) begin
                     cmd.fill_start = 1'b1;
                     cmd.fill_many  = 1'b1;
                     state_in       = ST_FILL;
                  end else begin
                     state_in = ST_RESPOND;
                  end
               end
               default: begin
                  state_in = ST_RESPOND;
               end
            endcase
         end
         ST_TAB_MOD: begin
            if (status.rem_done) begin
               cmd.tab_load = 1'b1;
               state_in     = ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put_step = 1'b1;
            if (status.put_wrap) begin
               cmd.fill_start = 1'b1;
               state_in       = ST_FILL;
            end else if (status.cnt_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = status.cnt_zero ? ST_RESPOND : ST_PUT;
            end
         end
         ST_SET_MOD: begin
            if (status.rem_done) begin
               cmd.cur_load = 1'b1;
               state_in     = ST_RESPOND;
            end
         end
         ST_RD_WAIT: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hw/rtl/text_console_char_writer.sv
// Top level of the text console character writer.
//
//   channel   ports                                   accepted at
//   request   start, busy, req_*                      edge with start high, busy low
//   response  rsp_valid, rsp_*                        edge ending the one-cycle strobe
//   config    csr_write_enable, csr_index, csr_*      edge with csr_write_enable high
//
// Each operation ends with the response strobe, which shows once the block is idle
// again, so the next beat can be taken while it shows. An out-of-range read or cursor
// set and a scroll by zero skip the store and go straight to the response.
// A tab first takes the start column mod the tab width in the remainder unit, then
// writes spaces up to the next tab stop; a scroll by n rows blanks n rows (at most
// ROWS), and a put that runs past the last cell blanks one row, one blank cell per
// cycle on the store's single write port. After reset the whole store is cleared with busy high.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps

module text_console_char_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [ATTR_W-1:0]     req_attr,
   input  logic [ADDR_W-1:0]     req_cell_addr,
   input  logic [ROWCNT_W-1:0]   req_row_count,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_cursor_pos,
   output logic [CHAR_W-1:0]     rsp_read_char,
   output logic [ATTR_W-1:0]     rsp_read_attr,
   output logic                  rsp_did_scroll,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int CELLS = COLUMNS * ROWS;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   tcw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   // Cell store and cursor datapath
   tcw_dp #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_attr        (req_attr),
      .req_cell_addr   (req_cell_addr),
      .req_row_count   (req_row_count),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_read_char   (rsp_read_char),
      .rsp_read_attr   (rsp_read_attr),
      .rsp_did_scroll  (rsp_did_scroll)
   );

`ifndef SYNTHESIS
   // One result per beat: strobes never touch
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held two cycles");

   // An accepted beat keeps the block busy until its response
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted beat");

   // The response leaves the block idle
   a_idle_on_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high while a response shows");

   // Cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_cursor_pos) < CELLS))
      else $error("cursor past the last cell");
`endif

endmodule
